FILE: hdl/csl_pkg.sv
// Shared types, constants and character-class helpers for the C subset lexer.
package csl_pkg;

   localparam int OFFSET_BITS = 16;
   localparam int START_BITS  = 16;
   localparam int LEN_BITS    = 16;
   localparam int VALUE_BITS  = 31;
   localparam int NUM_KW      = 6;

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

   typedef enum logic [2:0] {
      KIND_NUM     = 3'd0,
      KIND_IDENT   = 3'd1,
      KIND_KEYWORD = 3'd2,
      KIND_PUNCT   = 3'd3,
      KIND_END     = 3'd4,
      KIND_ERROR   = 3'd5
   } kind_type;

   typedef enum logic [3:0] {
      MODE_NONE  = 4'b0001,
      MODE_NUM   = 4'b0010,
      MODE_IDENT = 4'b0100,
      MODE_PUNCT = 4'b1000
   } mode_type;

   typedef struct packed {
      kind_type               kind;
      logic [START_BITS-1:0]  start;
      logic [LEN_BITS-1:0]    length;
      logic [VALUE_BITS-1:0]  value;
      logic                   last;
   } result_type;

   localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
      '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
      '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
      '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd6, 3'd2, 3'd4, 3'd3, 3'd5, 3'd3};

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_ident_first(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_ident_next(input logic [7:0] c);
      return is_ident_first(c) || is_digit(c);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_punct(input logic [7:0] c);
      return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
             (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
   endfunction

   // drop every keyword shorter than idx + 1 or whose character at idx differs from c
   function automatic logic [NUM_KW-1:0] next_mask(input logic [NUM_KW-1:0] mask,
                                                    input logic [LEN_BITS-1:0] idx,
                                                    input logic [7:0] c);
      logic [NUM_KW-1:0] m;
      m = mask;
      for (int k = 0; k < NUM_KW; k++) begin
         if (!(idx < LEN_BITS'(KW_LEN[k]) && KW_TEXT[k][idx[2:0]] == c)) begin
            m[k] = 1'b0;
         end
      end
      return m;
   endfunction

   function automatic logic keyword_hit(input logic [NUM_KW-1:0] mask,
                                        input logic [LEN_BITS-1:0] len);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k < NUM_KW; k++) begin
         if (mask[k] && len == LEN_BITS'(KW_LEN[k])) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

endpackage

FILE: hdl/c_subset_lexer.sv
// Streaming lexer for a small C subset: one source byte per request, tokens out.
//
// Requests (req_ch, req_is_end) are taken on req_valid && req_ready. Each
// request is classified in the cycle it is accepted and its tokens (zero, one
// or two) are written into a four-entry result queue; the first token of a
// request is registered there and reaches rsp_* once earlier ones are taken.
// Throughput is one request per cycle while req_ready is high. A request that
// yields two tokens (a flushed pending token plus a new one) takes two queue
// entries; the queue write port takes both at once, and req_ready is low only
// while the queue holds more than two tokens.
// A request with req_is_end flushes any pending token, emits the end token
// (rsp_last marks the final token of each request) and returns the lexer to
// its initial state; byte offsets restart at zero.
// When the receiver stalls (rsp_ready low) the head token holds on rsp_*
// and the queue fills; requests keep flowing until fewer than two entries
// are free.
// Reset (synchronous, active high) empties the queue and clears all lexer
// state; the first response can appear in the cycle after the first accept.
module c_subset_lexer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_ch,
   input  logic                           req_is_end,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [2:0]                     rsp_kind,
   output logic [csl_pkg::START_BITS-1:0] rsp_start_res,
   output logic [csl_pkg::LEN_BITS-1:0]   rsp_length,
   output logic [csl_pkg::VALUE_BITS-1:0] rsp_value,
   output logic                           rsp_last
);

   csl_pkg::mode_type                mode_ff, mode_in;
   logic [csl_pkg::OFFSET_BITS-1:0]  pos_ff, pos_in;
   logic [csl_pkg::OFFSET_BITS-1:0]  tstart_ff, tstart_in;
   logic [csl_pkg::LEN_BITS-1:0]     tlen_ff, tlen_in;
   logic [csl_pkg::VALUE_BITS-1:0]   acc_ff, acc_in;
   logic [csl_pkg::NUM_KW-1:0]       kmask_ff, kmask_in;
   logic                             error_ff, error_in;

   csl_pkg::result_type              queue_ff [csl_pkg::QUEUE_DEPTH];
   logic [csl_pkg::PTR_BITS-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [csl_pkg::CNT_BITS-1:0]     count_ff, count_in;

   logic                             accept, pop;
   logic                             flush_en, tok_en;
   csl_pkg::result_type              flush_res, tok_res, push0, push1;
   logic [1:0]                       n_push;
   logic [csl_pkg::LEN_BITS-1:0]     tlen_inc;
   logic [csl_pkg::VALUE_BITS+3:0]   acc_wide;
   logic [csl_pkg::VALUE_BITS-1:0]   acc_next;
   logic [7:0]                       digit;

   assign req_ready = count_ff <= csl_pkg::CNT_BITS'(csl_pkg::QUEUE_DEPTH - 2);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = count_ff != '0;
   assign pop       = rsp_valid && rsp_ready;

   assign rsp_kind      = queue_ff[rd_ptr_ff].kind;
   assign rsp_start_res = queue_ff[rd_ptr_ff].start;
   assign rsp_length    = queue_ff[rd_ptr_ff].length;
   assign rsp_value     = queue_ff[rd_ptr_ff].value;
   assign rsp_last      = queue_ff[rd_ptr_ff].last;

   assign digit    = req_ch - 8'd48;
   assign tlen_inc = (tlen_ff == '1) ? tlen_ff : tlen_ff + 1'b1;
   assign acc_wide = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) +
                     (csl_pkg::VALUE_BITS + 4)'(digit);
   assign acc_next = (acc_wide > (csl_pkg::VALUE_BITS + 4)'(csl_pkg::VALUE_MAX)) ?
                     csl_pkg::VALUE_MAX : acc_wide[csl_pkg::VALUE_BITS-1:0];

   always_comb begin
      flush_res       = '0;
      flush_res.start = csl_pkg::START_BITS'(tstart_ff);
      unique case (mode_ff)
         csl_pkg::MODE_NUM: begin
            flush_res.kind   = csl_pkg::KIND_NUM;
            flush_res.length = tlen_ff;
            flush_res.value  = acc_ff;
         end
         csl_pkg::MODE_IDENT: begin
            flush_res.kind   = csl_pkg::keyword_hit(kmask_ff, tlen_ff) ?
                               csl_pkg::KIND_KEYWORD : csl_pkg::KIND_IDENT;
            flush_res.length = tlen_ff;
         end
         csl_pkg::MODE_PUNCT: begin
            flush_res.kind   = csl_pkg::KIND_PUNCT;
            flush_res.length = csl_pkg::LEN_BITS'(1);
         end
         default: begin
            flush_res.kind = csl_pkg::KIND_NUM;
         end
      endcase
   end

   always_comb begin
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      tstart_in = tstart_ff;
      tlen_in   = tlen_ff;
      acc_in    = acc_ff;
      kmask_in  = kmask_ff;
      error_in  = error_ff;
      flush_en  = 1'b0;
      tok_en    = 1'b0;
      tok_res   = '0;
      tok_res.start = csl_pkg::START_BITS'(pos_ff);
      if (accept) begin
         if (req_is_end) begin
            flush_en     = mode_ff != csl_pkg::MODE_NONE;
            tok_en       = 1'b1;
            tok_res.kind = csl_pkg::KIND_END;
            mode_in      = csl_pkg::MODE_NONE;
            pos_in       = '0;
            tstart_in    = '0;
            tlen_in      = '0;
            acc_in       = '0;
            kmask_in     = '1;
            error_in     = 1'b0;
         end else begin
            pos_in = pos_ff + 1'b1;
            if (!error_ff) begin
               if (mode_ff == csl_pkg::MODE_NUM && csl_pkg::is_digit(req_ch)) begin
                  acc_in  = acc_next;
                  tlen_in = tlen_inc;
               end else if (mode_ff == csl_pkg::MODE_IDENT &&
                            csl_pkg::is_ident_next(req_ch)) begin
                  kmask_in = csl_pkg::next_mask(kmask_ff, tlen_ff, req_ch);
                  tlen_in  = tlen_inc;
               end else if (mode_ff == csl_pkg::MODE_PUNCT && req_ch == "=") begin
                  tok_en         = 1'b1;
                  tok_res.kind   = csl_pkg::KIND_PUNCT;
                  tok_res.start  = csl_pkg::START_BITS'(tstart_ff);
                  tok_res.length = csl_pkg::LEN_BITS'(2);
                  mode_in        = csl_pkg::MODE_NONE;
               end else begin
                  flush_en = mode_ff != csl_pkg::MODE_NONE;
                  mode_in  = csl_pkg::MODE_NONE;
                  if (csl_pkg::is_space(req_ch)) begin
                     mode_in = csl_pkg::MODE_NONE;
                  end else if (csl_pkg::is_digit(req_ch)) begin
                     mode_in   = csl_pkg::MODE_NUM;
                     tstart_in = pos_ff;
                     tlen_in   = csl_pkg::LEN_BITS'(1);
                     acc_in    = csl_pkg::VALUE_BITS'(digit);
                  end else if (csl_pkg::is_ident_first(req_ch)) begin
                     mode_in   = csl_pkg::MODE_IDENT;
                     tstart_in = pos_ff;
                     tlen_in   = csl_pkg::LEN_BITS'(1);
                     kmask_in  = csl_pkg::next_mask('1, '0, req_ch);
                  end else if (req_ch == "=" || req_ch == "!" ||
                               req_ch == "<" || req_ch == ">") begin
                     mode_in   = csl_pkg::MODE_PUNCT;
                     tstart_in = pos_ff;
                     tlen_in   = csl_pkg::LEN_BITS'(1);
                  end else if (csl_pkg::is_punct(req_ch)) begin
                     tok_en         = 1'b1;
                     tok_res.kind   = csl_pkg::KIND_PUNCT;
                     tok_res.length = csl_pkg::LEN_BITS'(1);
                  end else begin
                     tok_en         = 1'b1;
                     tok_res.kind   = csl_pkg::KIND_ERROR;
                     tok_res.length = csl_pkg::LEN_BITS'(1);
                     error_in       = 1'b1;
                  end
                  if (mode_in == csl_pkg::MODE_NONE) begin
                     acc_in   = '0;
                     tlen_in  = '0;
                     kmask_in = '1;
                  end
               end
            end
         end
      end
   end

   always_comb begin
      push0      = flush_en ? flush_res : tok_res;
      push0.last = !(flush_en && tok_en);
      push1      = tok_res;
      push1.last = 1'b1;
      n_push     = {1'b0, flush_en} + {1'b0, tok_en};
      count_in   = count_ff + csl_pkg::CNT_BITS'(n_push) -
                   csl_pkg::CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= csl_pkg::MODE_NONE;
         pos_ff    <= '0;
         tstart_ff <= '0;
         tlen_ff   <= '0;
         acc_ff    <= '0;
         kmask_ff  <= '1;
         error_ff  <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         tstart_ff <= tstart_in;
         tlen_ff   <= tlen_in;
         acc_ff    <= acc_in;
         kmask_ff  <= kmask_in;
         error_ff  <= error_in;
         wr_ptr_ff <= wr_ptr_ff + csl_pkg::PTR_BITS'(n_push);
         rd_ptr_ff <= rd_ptr_ff + csl_pkg::PTR_BITS'(pop);
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         queue_ff[wr_ptr_ff] <= push0;
      end
      if (n_push == 2'd2) begin
         queue_ff[wr_ptr_ff + 1'b1] <= push1;
      end
   end

endmodule

FILE: hdl/csl_checker.sv
// Port-level checks for the C subset lexer, bound to the top level.
module csl_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [2:0]                     rsp_kind,
   input logic [csl_pkg::LEN_BITS-1:0]   rsp_length,
   input logic [csl_pkg::VALUE_BITS-1:0] rsp_value,
   input logic                           rsp_last
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_last))
      else $error("stalled response dropped or changed");

   a_end_token: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == csl_pkg::KIND_END |->
         rsp_length == '0 && rsp_value == '0 && rsp_last)
      else $error("end token malformed");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != csl_pkg::KIND_NUM |-> rsp_value == '0)
      else $error("nonzero value on a non-number token");

   a_error_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == csl_pkg::KIND_ERROR || rsp_kind == csl_pkg::KIND_END ||
                    rsp_kind == csl_pkg::KIND_PUNCT) |-> rsp_length <= 16'd2)
      else $error("short token with wrong length");

endmodule

bind c_subset_lexer csl_checker u_csl_checker (.*);

FILE: tb/tb_c_subset_lexer.sv
// Self-checking testbench for the C subset lexer: directed table and random programs.
`timescale 1ns / 1ps

module tb_c_subset_lexer;

   localparam int STUCK_LIMIT = 1000;
   localparam int RANDOM_REQUESTS = 1150;

   typedef struct packed {
      logic [7:0]                     ch;
      logic                           is_end;
      logic                           typed;
      csl_pkg::kind_type              kind;
      logic [csl_pkg::START_BITS-1:0] start;
      logic [csl_pkg::LEN_BITS-1:0]   length;
      logic [csl_pkg::VALUE_BITS-1:0] value;
   } stim_row_type;

   logic                           clock;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [7:0]                     req_ch = 8'h00;
   logic                           req_is_end = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [2:0]                     rsp_kind;
   logic [csl_pkg::START_BITS-1:0] rsp_start_res;
   logic [csl_pkg::LEN_BITS-1:0]   rsp_length;
   logic [csl_pkg::VALUE_BITS-1:0] rsp_value;
   logic                           rsp_last;

   // lexer state mirrored by the predictor
   csl_pkg::mode_type               lex_mode;
   logic [csl_pkg::OFFSET_BITS-1:0] lex_pos;
   logic [csl_pkg::START_BITS-1:0]  tok_start;
   logic [csl_pkg::LEN_BITS-1:0]    tok_len;
   logic [csl_pkg::VALUE_BITS-1:0]  num_acc;
   logic [csl_pkg::NUM_KW-1:0]      kw_mask;
   logic                            err_seen;

   csl_pkg::result_type lex_out[$];
   csl_pkg::result_type tokens_due[$];
   csl_pkg::result_type head_token;
   int         mismatch_count = 0;
   int         requests_sent = 0;
   int         stuck_cycles = 0;
   logic       quiet_sender = 1'b0;

   string keywords[csl_pkg::NUM_KW] = '{"return", "if", "else", "for", "while", "int"};
   string word_pool[21] = '{"return", "if", "else", "for", "while", "int", "retur", "i", "els",
                            "fo", "whil", "in", "ifx", "int8", "returned", "For", "INT", "_if",
                            "2147483647", "2147483648", "0"};
   string ident_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
   string compare_chars = "=!<>";
   logic [7:0] blank_chars[6] = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};

   stim_row_type directed_rows[22] = '{
      '{8'h00, 1'b1, 1'b1, csl_pkg::KIND_END,   16'd0,  16'd0, 31'd0},
      '{"i",   1'b0, 1'b0, csl_pkg::KIND_NUM,   16'd0,  16'd0, 31'd0},
      '{"f",   1'b0, 1'b0, csl_pkg::KIND_NUM,   16'd0,  16'd0, 31'd0},
      '{"=",   1'b0, 1'b0, csl_pkg::KIND_NUM,   16'd0,  16'd0, 31'd0},
      '{"=",   1'b0, 1'b0, csl_pkg::KIND_NUM,   16'd0,  16'd0, 31'd0},
      '{"<",   1'b0, 1'b0, csl_pkg::KIND_NUM,   16'd0,  16'd0, 31'd0},
      '{"x",   1'b0, 1'b0, csl_pkg::KIND_NUM,   16'd0,  16'd0, 31'd0},
      '{"_",   1'b0, 1'b0, csl_pkg::KIND_NUM,   16'd0,  16'd0, 31'd0},
      '{"9",   1'b0, 1'b0, csl_pkg::KIND_NUM,   16'd0,  16'd0, 31'd0},
      '{"~",   1'b0, 1'b0, csl_pkg::KIND_NUM,   16'd0,  16'd0, 31'd0},
      '{"0",   1'b0, 1'b0, csl_pkg::KIND_NUM,   16'd0,  16'd0, 31'd0},
      '{"9",   1'b0, 1'b0, csl_pkg::KIND_NUM,   16'd0,  16'd0, 31'd0},
      '{8'h09, 1'b0, 1'b0, csl_pkg::KIND_NUM,   16'd0,  16'd0, 31'd0},
      '{8'hFF, 1'b0, 1'b1, csl_pkg::KIND_ERROR, 16'd12, 16'd1, 31'd0},
      '{8'h00, 1'b0, 1'b0, csl_pkg::KIND_NUM,   16'd0,  16'd0, 31'd0},
      '{"!",   1'b0, 1'b0, csl_pkg::KIND_NUM,   16'd0,  16'd0, 31'd0},
      '{8'hA5, 1'b1, 1'b1, csl_pkg::KIND_END,   16'd15, 16'd0, 31'd0},
      '{">",   1'b0, 1'b0, csl_pkg::KIND_NUM,   16'd0,  16'd0, 31'd0},
      '{"=",   1'b1, 1'b0, csl_pkg::KIND_NUM,   16'd0,  16'd0, 31'd0},
      '{"Z",   1'b0, 1'b0, csl_pkg::KIND_NUM,   16'd0,  16'd0, 31'd0},
      '{8'h7F, 1'b0, 1'b0, csl_pkg::KIND_NUM,   16'd0,  16'd0, 31'd0},
      '{8'h00, 1'b1, 1'b1, csl_pkg::KIND_END,   16'd2,  16'd0, 31'd0}
   };

   c_subset_lexer uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_ch        (req_ch),
      .req_is_end    (req_is_end),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_start_res (rsp_start_res),
      .rsp_length    (rsp_length),
      .rsp_value     (rsp_value),
      .rsp_last      (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic is_dec_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_word_start(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_mark(input logic [7:0] c);
      return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
             (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
   endfunction

   function automatic void clear_lexer();
      lex_mode  = csl_pkg::MODE_NONE;
      lex_pos   = '0;
      tok_start = '0;
      tok_len   = '0;
      num_acc   = '0;
      kw_mask   = '1;
      err_seen  = 1'b0;
   endfunction

   function automatic void emit(input csl_pkg::kind_type k,
                                input logic [csl_pkg::START_BITS-1:0] s,
                                input logic [csl_pkg::LEN_BITS-1:0] l,
                                input logic [csl_pkg::VALUE_BITS-1:0] v);
      csl_pkg::result_type t;
      t.kind   = k;
      t.start  = s;
      t.length = l;
      t.value  = v;
      t.last   = 1'b0;
      lex_out.push_back(t);
   endfunction

   function automatic void mark_last();
      if (lex_out.size() > 0) lex_out[lex_out.size() - 1].last = 1'b1;
   endfunction

   function automatic void bump_length();
      if (tok_len != '1) tok_len = tok_len + 1'b1;
   endfunction

   // narrow the keyword candidates by the byte at the current token index
   function automatic void narrow_keywords(input logic [7:0] c);
      logic keep;
      for (int k = 0; k < csl_pkg::NUM_KW; k++) begin
         keep = 1'b0;
         if (tok_len < keywords[k].len()) keep = (keywords[k][tok_len] == c);
         if (!keep) kw_mask[k] = 1'b0;
      end
   endfunction

   function automatic void flush_pending();
      csl_pkg::kind_type k;
      case (lex_mode)
         csl_pkg::MODE_NUM: begin
            emit(csl_pkg::KIND_NUM, tok_start, tok_len, num_acc);
         end
         csl_pkg::MODE_IDENT: begin
            k = csl_pkg::KIND_IDENT;
            for (int i = 0; i < csl_pkg::NUM_KW; i++) begin
               if (kw_mask[i] && tok_len == keywords[i].len()) k = csl_pkg::KIND_KEYWORD;
            end
            emit(k, tok_start, tok_len, '0);
         end
         csl_pkg::MODE_PUNCT: begin
            emit(csl_pkg::KIND_PUNCT, tok_start, 16'd1, '0);
         end
         default: begin
         end
      endcase
      lex_mode = csl_pkg::MODE_NONE;
   endfunction

   function automatic void open_token(input csl_pkg::mode_type m,
                                      input logic [csl_pkg::START_BITS-1:0] at);
      lex_mode  = m;
      tok_start = at;
      tok_len   = 16'd1;
   endfunction

   // tokens caused by one request, in order, into lex_out
   function automatic void lex_byte(input logic [7:0] c, input logic is_end);
      logic [csl_pkg::START_BITS-1:0] at;
      longint unsigned                acc;
      lex_out.delete();
      if (is_end) begin
         flush_pending();
         emit(csl_pkg::KIND_END, lex_pos, '0, '0);
         mark_last();
         clear_lexer();
         return;
      end
      at = lex_pos;
      lex_pos = lex_pos + 1'b1;
      if (err_seen) return;
      if (lex_mode == csl_pkg::MODE_NUM && is_dec_digit(c)) begin
         acc = 64'(num_acc) * 64'd10 + 64'(c) - 64'd48;
         num_acc = (acc > 64'(csl_pkg::VALUE_MAX)) ? csl_pkg::VALUE_MAX :
                   acc[csl_pkg::VALUE_BITS-1:0];
         bump_length();
         return;
      end
      if (lex_mode == csl_pkg::MODE_IDENT && (is_word_start(c) || is_dec_digit(c))) begin
         narrow_keywords(c);
         bump_length();
         return;
      end
      if (lex_mode == csl_pkg::MODE_PUNCT && c == "=") begin
         emit(csl_pkg::KIND_PUNCT, tok_start, 16'd2, '0);
         lex_mode = csl_pkg::MODE_NONE;
         mark_last();
         return;
      end
      flush_pending();
      if (is_blank(c)) begin
      end else if (is_dec_digit(c)) begin
         open_token(csl_pkg::MODE_NUM, at);
         num_acc = csl_pkg::VALUE_BITS'(c - 8'd48);
      end else if (is_word_start(c)) begin
         kw_mask = '1;
         tok_len = '0;
         narrow_keywords(c);
         open_token(csl_pkg::MODE_IDENT, at);
      end else if (c == "=" || c == "!" || c == "<" || c == ">") begin
         open_token(csl_pkg::MODE_PUNCT, at);
      end else if (is_mark(c)) begin
         emit(csl_pkg::KIND_PUNCT, at, 16'd1, '0);
      end else begin
         emit(csl_pkg::KIND_ERROR, at, 16'd1, '0);
         err_seen = 1'b1;
      end
      if (lex_mode == csl_pkg::MODE_NONE) begin
         num_acc = '0;
         tok_len = '0;
         kw_mask = '1;
      end
      mark_last();
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic logic [7:0] random_mark();
      logic [7:0] c;
      do c = 8'($urandom_range(33, 126)); while (!is_mark(c) || c == "_");
      return c;
   endfunction

   task automatic drive_request(input logic [7:0] c, input logic is_end);
      int gap;
      gap = quiet_sender ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_ch     <= c;
      req_is_end <= is_end;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
   endtask

   task automatic send_byte(input logic [7:0] c, input logic is_end);
      drive_request(c, is_end);
      lex_byte(c, is_end);
      foreach (lex_out[i]) tokens_due.push_back(lex_out[i]);
   endtask

   // one source text of random tokens, mostly well formed, closed by an end request
   task automatic send_program();
      logic [7:0] text[$];
      string      w;
      int         n_tok;
      int         r;
      int         len;
      quiet_sender = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 19) == 0) begin
         len = $urandom_range(1, 16);
         repeat (len) text.push_back(8'($urandom_range(0, 255)));
      end else begin
         n_tok = $urandom_range(1, 12);
         repeat (n_tok) begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
               w = word_pool[$urandom_range(0, 20)];
               for (int i = 0; i < w.len(); i++) text.push_back(w[i]);
            end else if (r < 40) begin
               text.push_back(ident_chars[$urandom_range(0, 52)]);
               len = $urandom_range(0, 10);
               repeat (len) text.push_back(ident_chars[$urandom_range(0, 62)]);
            end else if (r < 60) begin
               len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 4);
               repeat (len) text.push_back(8'd48 + 8'($urandom_range(0, 9)));
            end else if (r < 75) begin
               text.push_back(compare_chars[$urandom_range(0, 3)]);
               if ($urandom_range(0, 1) == 1) text.push_back("=");
            end else if (r < 97) begin
               text.push_back(random_mark());
            end else begin
               text.push_back(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 99) < 60) begin
               len = $urandom_range(1, 2);
               repeat (len) text.push_back(blank_chars[$urandom_range(0, 5)]);
            end
         end
      end
      foreach (text[i]) send_byte(text[i], 1'b0);
      send_byte(8'($urandom_range(0, 255)), 1'b1);
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (tokens_due.size() == 0) begin
            $error("token with none outstanding: kind %0d start %0d length %0d",
                   rsp_kind, rsp_start_res, rsp_length);
            mismatch_count++;
         end else begin
            head_token = tokens_due.pop_front();
            check_field("kind", 32'(head_token.kind), 32'(rsp_kind));
            check_field("start_res", 32'(head_token.start), 32'(rsp_start_res));
            check_field("length", 32'(head_token.length), 32'(rsp_length));
            check_field("value", 32'(head_token.value), 32'(rsp_value));
            check_field("last", 32'(head_token.last), 32'(rsp_last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      int run_len;
      int stall_len;
      int r;
      while (reset) @(posedge clock);
      forever begin
         run_len = $urandom_range(1, 40);
         rsp_ready <= 1'b1;
         repeat (run_len) @(posedge clock);
         r = $urandom_range(0, 99);
         if (r < 45) stall_len = 0;
         else if (r < 88) stall_len = $urandom_range(1, 3);
         else stall_len = $urandom_range(4, 25);
         if (stall_len > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall_len) @(posedge clock);
         end
      end
   end

   initial begin
      csl_pkg::result_type typed_token;
      clear_lexer();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         drive_request(directed_rows[i].ch, directed_rows[i].is_end);
         lex_byte(directed_rows[i].ch, directed_rows[i].is_end);
         if (directed_rows[i].typed) begin
            typed_token.kind   = directed_rows[i].kind;
            typed_token.start  = directed_rows[i].start;
            typed_token.length = directed_rows[i].length;
            typed_token.value  = directed_rows[i].value;
            typed_token.last   = 1'b1;
            tokens_due.push_back(typed_token);
         end else begin
            foreach (lex_out[j]) tokens_due.push_back(lex_out[j]);
         end
      end

      while (requests_sent < RANDOM_REQUESTS) send_program();

      req_valid <= 1'b0;
      while (tokens_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
